// File: rtl/core/chti_pkg.sv
package chti_pkg;

   localparam int MaxKnots   = 64;
   localparam int IdxW       = 6;
   localparam int CntW       = 7;
   localparam int FracBits   = 16;
   localparam int TW         = FracBits + 1;
   localparam int PW         = 44;
   localparam int ProdW      = PW + TW;
   localparam int ReqDataW   = 104;
   localparam int RspDataW   = 40;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DIV,
      ST_Y_RD,
      ST_Y_CAP,
      ST_COEF,
      ST_MUL,
      ST_ADD,
      ST_FIN
   } state_type;

endpackage

// File: rtl/core/cubic_hermite_table_interpolator_core.sv
// Channel | Direction | Handshake                  | Payload
// req     | in        | req_tvalid / req_tready    | tuser: cmd; tdata: index, x, y, u
// rsp     | out       | rsp_tvalid / rsp_tready    | tuser: outside_range; tdata: value, segment
// csr     | in        | csr_we                     | csr_wdata: knot_count
//
// A knot write item is written to the knot tables as it is accepted. A query
// item runs the segment search (one knot table read port, one compare per knot),
// the bit-serial division, the four y reads, then the coefficients, the three
// Horner steps on the shared multiplier and the final rounding.
// Reset is synchronous and active high; it clears the sequencer, the response
// valid flag and sets knot_count to 2. The knot tables are not cleared.
// A finished result waits in the output register; a new item is accepted
// meanwhile, and the sequencer stalls at the final step only if the previous
// result has still not been taken.
module cubic_hermite_table_interpolator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: knot_index[5:0], knot_x[31:0], knot_y[31:0], query_u[31:0], pad.
   input  logic [chti_pkg::ReqDataW-1:0]      req_tdata,
   // Fields from bit 0: cmd.
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: curve_value[31:0], segment_found[5:0], pad.
   output logic [chti_pkg::RspDataW-1:0]      rsp_tdata,
   // Fields from bit 0: outside_range.
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [chti_pkg::CntW-1:0]          csr_wdata
);

   localparam int PW = chti_pkg::PW;
   localparam int TW = chti_pkg::TW;
   localparam int FB = chti_pkg::FracBits;

   // Knot tables, one write and one registered read port each.
   logic signed [31:0] x_mem [chti_pkg::MaxKnots];
   logic signed [31:0] y_mem [chti_pkg::MaxKnots];
   logic signed [31:0] x_rd_ff, y_rd_ff;
   logic [chti_pkg::IdxW-1:0] y_addr;

   chti_pkg::state_type state_ff, state_in;
   logic [chti_pkg::CntW-1:0] knot_count_ff, knot_count_in;
   logic [chti_pkg::CntW-1:0] n_ff, n_in;
   logic signed [31:0] u_ff, u_in, prev_ff, prev_in, x0_ff, x0_in;
   logic [chti_pkg::IdxW-1:0] k_ff, k_in, seg_ff, seg_in;
   logic found_ff, found_in;
   logic [31:0] rem_ff, rem_in, den_ff, den_in;
   logic [TW-1:0] t_ff, t_in;
   logic [3:0] bit_ff, bit_in;
   logic [1:0] yi_ff, yi_in, h_ff, h_in;
   logic signed [31:0] ya_ff, ya_in, yb_ff, yb_in, yc_ff, yc_in, yd_ff, yd_in;
   logic signed [PW-1:0] a2_ff, a2_in, b2_ff, b2_in, c2_ff, c2_in, d2_ff, d2_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic [chti_pkg::ProdW-1:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [chti_pkg::IdxW-1:0] rsp_seg_ff, rsp_seg_in;
   logic rsp_out_ff, rsp_out_in;

   logic req_fire, wr_fire;
   logic [chti_pkg::IdxW-1:0] last_idx;
   logic [chti_pkg::CntW-1:0] ip2_wide;
   logic [32:0] div_trial;
   logic signed [PW-1:0] ea, eb, ec, ed, coef, shifted, mag_p;
   logic [PW-1:0] abs_p, half;
   logic signed [PW-1:0] y_full;
   logic signed [32:0] x_diff;

   assign req_tready = (state_ff == chti_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_fire    = req_fire && (req_tuser == chti_pkg::CMD_WRITE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_seg_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_out_ff;

   assign last_idx = chti_pkg::IdxW'(n_ff - chti_pkg::CntW'(1));
   assign ip2_wide = (chti_pkg::CntW'(seg_ff) + chti_pkg::CntW'(2) > n_ff - chti_pkg::CntW'(1))
                   ? n_ff - chti_pkg::CntW'(1) : chti_pkg::CntW'(seg_ff) + chti_pkg::CntW'(2);

   // Neighbor index for each of the four y reads, clamped at the table ends.
   always_comb begin
      unique case (yi_ff)
         2'd0:    y_addr = (seg_ff == '0) ? '0 : seg_ff - chti_pkg::IdxW'(1);
         2'd1:    y_addr = seg_ff;
         2'd2:    y_addr = seg_ff + chti_pkg::IdxW'(1);
         default: y_addr = ip2_wide[chti_pkg::IdxW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         x_mem[req_tdata[5:0]] <= req_tdata[37:6];
         y_mem[req_tdata[5:0]] <= req_tdata[69:38];
      end
      x_rd_ff <= x_mem[k_ff];
      y_rd_ff <= y_mem[y_addr];
   end

   assign ea = PW'(ya_ff);
   assign eb = PW'(yb_ff);
   assign ec = PW'(yc_ff);
   assign ed = PW'(yd_ff);
   assign div_trial = {rem_ff, 1'b0} - {1'b0, den_ff};
   assign x_diff = 33'(x_rd_ff) - 33'(prev_ff);
   assign abs_p = p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff);
   assign shifted = PW'(prod_ff[PW+FB-1:FB]);
   assign mag_p = neg_ff ? -shifted : shifted;
   assign half = abs_p >> 1;
   assign y_full = p_ff[PW-1] ? -$signed(half) : $signed(half);

   always_comb begin
      unique case (h_ff)
         2'd0:    coef = b2_ff;
         2'd1:    coef = c2_ff;
         default: coef = d2_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      knot_count_in = csr_we ? csr_wdata : knot_count_ff;
      n_in = n_ff;       u_in = u_ff;       prev_in = prev_ff;   x0_in = x0_ff;
      k_in = k_ff;       seg_in = seg_ff;   found_in = found_ff;
      rem_in = rem_ff;   den_in = den_ff;   t_in = t_ff;         bit_in = bit_ff;
      yi_in = yi_ff;     h_in = h_ff;
      ya_in = ya_ff;     yb_in = yb_ff;     yc_in = yc_ff;       yd_in = yd_ff;
      a2_in = a2_ff;     b2_in = b2_ff;     c2_in = c2_ff;       d2_in = d2_ff;
      p_in = p_ff;       prod_in = prod_ff; neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff; rsp_seg_in = rsp_seg_ff; rsp_out_in = rsp_out_ff;

      unique case (state_ff)
         chti_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == chti_pkg::CMD_QUERY) begin
               // Clamp the active count into the table size.
               if (knot_count_ff < chti_pkg::CntW'(2)) begin
                  n_in = chti_pkg::CntW'(2);
               end else if (knot_count_ff > chti_pkg::CntW'(chti_pkg::MaxKnots)) begin
                  n_in = chti_pkg::CntW'(chti_pkg::MaxKnots);
               end else begin
                  n_in = knot_count_ff;
               end
               u_in = req_tdata[101:70];
               k_in = '0;
               state_in = chti_pkg::ST_SRCH_RD;
            end
         end
         chti_pkg::ST_SRCH_RD: begin
            state_in = chti_pkg::ST_SRCH_CMP;
         end
         chti_pkg::ST_SRCH_CMP: begin
            if (k_ff == '0) begin
               x0_in = x_rd_ff;
               prev_in = x_rd_ff;
               k_in = k_ff + chti_pkg::IdxW'(1);
               state_in = chti_pkg::ST_SRCH_RD;
            end else if (prev_ff <= u_ff && u_ff < x_rd_ff) begin
               // Segment found: the quotient (u - x[k-1]) / (x[k] - x[k-1]) is below one.
               seg_in = k_ff - chti_pkg::IdxW'(1);
               found_in = 1'b1;
               rem_in = 32'(33'(u_ff) - 33'(prev_ff));
               den_in = x_diff[31:0];
               t_in = '0;
               bit_in = '0;
               state_in = chti_pkg::ST_DIV;
            end else if (k_ff == last_idx) begin
               found_in = 1'b0;
               yi_in = '0;
               state_in = chti_pkg::ST_Y_RD;
               if (u_ff < x0_ff) begin
                  seg_in = '0;
                  t_in = '0;
               end else begin
                  seg_in = chti_pkg::IdxW'(n_ff - chti_pkg::CntW'(2));
                  t_in = TW'(1) << FB;
               end
            end else begin
               prev_in = x_rd_ff;
               k_in = k_ff + chti_pkg::IdxW'(1);
               state_in = chti_pkg::ST_SRCH_RD;
            end
         end
         chti_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (!div_trial[32]) begin
               rem_in = div_trial[31:0];
               t_in = {t_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], 1'b0};
               t_in = {t_ff[TW-2:0], 1'b0};
            end
            bit_in = bit_ff + 4'd1;
            if (bit_ff == 4'(FB - 1)) begin
               yi_in = '0;
               state_in = chti_pkg::ST_Y_RD;
            end
         end
         chti_pkg::ST_Y_RD: begin
            state_in = chti_pkg::ST_Y_CAP;
         end
         chti_pkg::ST_Y_CAP: begin
            unique case (yi_ff)
               2'd0:    ya_in = y_rd_ff;
               2'd1:    yb_in = y_rd_ff;
               2'd2:    yc_in = y_rd_ff;
               default: yd_in = y_rd_ff;
            endcase
            yi_in = yi_ff + 2'd1;
            state_in = (yi_ff == 2'd3) ? chti_pkg::ST_COEF : chti_pkg::ST_Y_RD;
         end
         chti_pkg::ST_COEF: begin
            a2_in = (ed - ea) + ((eb - ec) <<< 1) + (eb - ec);
            b2_in = (ea <<< 1) - (eb <<< 2) - eb + (ec <<< 2) - ed;
            c2_in = ec - ea;
            d2_in = eb <<< 1;
            p_in = (ed - ea) + ((eb - ec) <<< 1) + (eb - ec);
            h_in = '0;
            state_in = chti_pkg::ST_MUL;
         end
         chti_pkg::ST_MUL: begin
            // Magnitude times t on the shared multiplier; sign applied after.
            prod_in = chti_pkg::ProdW'(abs_p) * chti_pkg::ProdW'(t_ff);
            neg_in = p_ff[PW-1];
            state_in = chti_pkg::ST_ADD;
         end
         chti_pkg::ST_ADD: begin
            p_in = mag_p + coef;
            h_in = h_ff + 2'd1;
            state_in = (h_ff == 2'd2) ? chti_pkg::ST_FIN : chti_pkg::ST_MUL;
         end
         chti_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (y_full > PW'(32'sh7FFFFFFF)) begin
                  rsp_value_in = 32'sh7FFFFFFF;
               end else if (y_full < -PW'(33'sh080000000)) begin
                  rsp_value_in = 32'sh80000000;
               end else begin
                  rsp_value_in = y_full[31:0];
               end
               rsp_seg_in = seg_ff;
               rsp_out_in = !found_ff;
               state_in = chti_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chti_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chti_pkg::ST_IDLE;
         knot_count_ff <= chti_pkg::CntW'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         knot_count_ff <= knot_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;       u_ff <= u_in;       prev_ff <= prev_in;  x0_ff <= x0_in;
      k_ff <= k_in;       seg_ff <= seg_in;   found_ff <= found_in;
      rem_ff <= rem_in;   den_ff <= den_in;   t_ff <= t_in;        bit_ff <= bit_in;
      yi_ff <= yi_in;     h_ff <= h_in;
      ya_ff <= ya_in;     yb_ff <= yb_in;     yc_ff <= yc_in;      yd_ff <= yd_in;
      a2_ff <= a2_in;     b2_ff <= b2_in;     c2_ff <= c2_in;      d2_ff <= d2_in;
      p_ff <= p_in;       prod_ff <= prod_in; neg_ff <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_out_ff <= rsp_out_in;
   end

endmodule
